// File: hdl/cmm_pkg.sv
// shared constants and types for the cannon matrix multiply block
`timescale 1ns / 1ps
package cmm_pkg;

   localparam int IDX_W              = 3;
   localparam int ADDR_W             = 2 * IDX_W;
   localparam int STORE_DEPTH        = 1 << ADDR_W;
   localparam int ELEM_W             = 16;
   localparam int MUL_W              = 2 * ELEM_W;
   localparam int PROD_W             = 35;
   localparam int MATRIX_DIM_DEFAULT = 8;

   localparam int REQ_FIELDS_W = 2 * IDX_W + 2 * ELEM_W;
   localparam int REQ_DATA_W   = ((REQ_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_FIELDS_W = 2 * IDX_W + PROD_W;
   localparam int RSP_DATA_W   = ((RSP_FIELDS_W + 7) / 8) * 8;

   localparam logic MODE_LOAD = 1'b0;
   localparam logic MODE_RUN  = 1'b1;

   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_tag_type;

endpackage

// File: hdl/cmm_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps
module cmm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/cmm_mac.sv
// shared multiply-accumulate unit, one term per cycle, two register stages
`timescale 1ns / 1ps
module cmm_mac (
   input  logic                                clock,
   input  logic                                reset,
   input  cmm_pkg::mac_tag_type                tag,
   input  logic signed [cmm_pkg::ELEM_W-1:0]   a_term,
   input  logic signed [cmm_pkg::ELEM_W-1:0]   b_term,
   output logic signed [cmm_pkg::PROD_W-1:0]   sum,
   output logic                                done
);
   import cmm_pkg::*;

   logic signed [MUL_W-1:0]  prod_ff, prod_in;
   mac_tag_type              tag_ff, tag_in;
   logic signed [PROD_W-1:0] acc_ff, acc_in;
   logic                     done_ff, done_in;
   logic signed [PROD_W-1:0] prod_ext;

   assign prod_ext = {{(PROD_W - MUL_W){prod_ff[MUL_W-1]}}, prod_ff};

   always_comb begin
      prod_in = a_term * b_term;
      tag_in  = tag;
      acc_in  = acc_ff;
      if (tag_ff.valid) begin
         acc_in = tag_ff.first ? prod_ext : acc_ff + prod_ext;
      end
      done_in = tag_ff.valid & tag_ff.last;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      if (reset) begin
         tag_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         tag_ff  <= tag_in;
         done_ff <= done_in;
      end
   end

   assign sum  = acc_ff;
   assign done = done_ff;

endmodule

// File: hdl/cannon_matrix_multiply.sv
// top level: element stores, sequencer and result register of the matrix product
`timescale 1ns / 1ps
// Square matrix product C = A * B on signed Q8.8 elements with exact Q19.16 sums.
// An item with tuser low writes one element of A and one of B at (row, col);
// writes outside the matrix are dropped. An item with tuser high runs the
// product and returns MATRIX_DIM * MATRIX_DIM results in row-major order, tlast on
// the final one. One multiplier is shared by all terms: each result runs
// MATRIX_DIM multiply-accumulate terms through the store read, multiply and
// accumulate registers, and a new result does not start while the result
// side stalls with an earlier result still pending. Elements that were never
// written read as unknown values.
module cannon_matrix_multiply #(
   parameter int MATRIX_DIM = cmm_pkg::MATRIX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [cmm_pkg::REQ_DATA_W-1:0]  req_tdata,  // row, col, a_value, b_value
   input  logic                            req_tuser,  // mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [cmm_pkg::RSP_DATA_W-1:0]  rsp_tdata,  // out_row, out_col, product_value
   output logic                            rsp_tlast   // last
);
   import cmm_pkg::*;

   localparam logic [IDX_W:0]   DIM_LIMIT = (IDX_W + 1)'(MATRIX_DIM);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(MATRIX_DIM - 1);

   typedef enum logic [1:0] {
      S_IDLE,
      S_ISSUE,
      S_WAIT
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     i_ff, i_in;
   logic [IDX_W-1:0]     j_ff, j_in;
   logic [IDX_W-1:0]     k_ff, k_in;
   mac_tag_type          tag_ff, tag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     rsp_row_ff, rsp_row_in;
   logic [IDX_W-1:0]     rsp_col_ff, rsp_col_in;
   logic [PROD_W-1:0]    rsp_value_ff, rsp_value_in;
   logic                 rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]     req_row;
   logic [IDX_W-1:0]     req_col;
   logic [ELEM_W-1:0]    req_a;
   logic [ELEM_W-1:0]    req_b;
   logic                 req_fire;
   logic                 load_en;
   logic                 rsp_free;
   logic [ELEM_W-1:0]    a_rd;
   logic [ELEM_W-1:0]    b_rd;
   logic signed [PROD_W-1:0] mac_sum;
   logic                 mac_done;

   assign req_row = req_tdata[IDX_W-1:0];
   assign req_col = req_tdata[2*IDX_W-1:IDX_W];
   assign req_a   = req_tdata[2*IDX_W+ELEM_W-1:2*IDX_W];
   assign req_b   = req_tdata[2*IDX_W+2*ELEM_W-1:2*IDX_W+ELEM_W];

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign load_en    = req_fire && (req_tuser == MODE_LOAD) &&
                       ({1'b0, req_row} < DIM_LIMIT) && ({1'b0, req_col} < DIM_LIMIT);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   cmm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (STORE_DEPTH)
   ) u_a_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_a),
      .rd_addr ({i_ff, k_ff}),
      .rd_data (a_rd)
   );

   cmm_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (STORE_DEPTH)
   ) u_b_store (
      .clock   (clock),
      .wr_en   (load_en),
      .wr_addr ({req_row, req_col}),
      .wr_data (req_b),
      .rd_addr ({k_ff, j_ff}),
      .rd_data (b_rd)
   );

   cmm_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .tag    (tag_ff),
      .a_term (signed'(a_rd)),
      .b_term (signed'(b_rd)),
      .sum    (mac_sum),
      .done   (mac_done)
   );

   always_comb begin
      state_in     = state_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      tag_in       = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire && (req_tuser == MODE_RUN)) begin
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            // a result starts only when the output register will be empty for it
            if (k_ff != '0 || rsp_free) begin
               tag_in.valid = 1'b1;
               tag_in.first = (k_ff == '0);
               tag_in.last  = (k_ff == LAST_IDX);
               if (k_ff == LAST_IDX) begin
                  k_in     = '0;
                  state_in = S_WAIT;
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         S_WAIT: begin
            if (mac_done) begin
               rsp_valid_in = 1'b1;
               rsp_row_in   = i_ff;
               rsp_col_in   = j_ff;
               rsp_value_in = mac_sum;
               rsp_last_in  = (i_ff == LAST_IDX) && (j_ff == LAST_IDX);
               state_in     = S_ISSUE;
               if (j_ff == LAST_IDX) begin
                  j_in = '0;
                  if (i_ff == LAST_IDX) begin
                     i_in     = '0;
                     state_in = S_IDLE;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         k_ff         <= '0;
         tag_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         k_ff         <= k_in;
         tag_ff       <= tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - RSP_FIELDS_W){1'b0}}, rsp_value_ff, rsp_col_ff, rsp_row_ff};

`ifndef SYNTH
   // a finished sum only arrives while the sequencer waits for it
   assert property (@(posedge clock) disable iff (reset) mac_done |-> state_ff == S_WAIT)
      else $error("sum finished outside the wait state");

   // the output register is always free when a sum lands
   assert property (@(posedge clock) disable iff (reset) mac_done |-> !rsp_valid_ff)
      else $error("sum would overwrite a pending result");

   // no input is taken while a product is being computed
   assert property (@(posedge clock) disable iff (reset)
      (tag_ff.valid || mac_done) |-> !req_tready)
      else $error("input ready during a run");
`endif

endmodule

// File: dv/cannon_matrix_multiply_tb.sv
// self-checking testbench for the cannon matrix multiply block
`timescale 1ns / 1ps
module cannon_matrix_multiply_tb;
   import cmm_pkg::*;

   localparam int DIM      = MATRIX_DIM_DEFAULT;
   localparam int RUN_ODDS = 16;

   typedef struct packed {
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic [PROD_W-1:0] value;
      logic              last;
   } product_item_type;

   class product_scoreboard;
      logic [ELEM_W-1:0] a_store [STORE_DEPTH];
      logic [ELEM_W-1:0] b_store [STORE_DEPTH];
      product_item_type  expected_products [$];
      int unsigned       mismatches;

      function new();
         mismatches = 0;
      endfunction

      function int pending();
         return expected_products.size();
      endfunction

      // exact dot products, queued in row-major order
      function void compute_products();
         longint           acc;
         product_item_type item;
         for (int i = 0; i < DIM; i++) begin
            for (int j = 0; j < DIM; j++) begin
               acc = 0;
               for (int k = 0; k < DIM; k++) begin
                  acc += longint'($signed(a_store[i * 8 + k])) *
                         longint'($signed(b_store[k * 8 + j]));
               end
               item.row   = IDX_W'(i);
               item.col   = IDX_W'(j);
               item.value = acc[PROD_W-1:0];
               item.last  = (i == DIM - 1) && (j == DIM - 1);
               expected_products.push_back(item);
            end
         end
      endfunction

      function void note_request(logic mode, logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                 logic [ELEM_W-1:0] a_value, logic [ELEM_W-1:0] b_value);
         if (mode == MODE_RUN) begin
            compute_products();
         end else if (row < DIM && col < DIM) begin
            a_store[row * 8 + col] = a_value;
            b_store[row * 8 + col] = b_value;
         end
      endfunction

      function void check_result(logic [IDX_W-1:0] row, logic [IDX_W-1:0] col,
                                 logic [PROD_W-1:0] value, logic last);
         product_item_type want;
         if (expected_products.size() == 0) begin
            $error("unexpected result row %0d col %0d value %0d", row, col, $signed(value));
            mismatches++;
            return;
         end
         want = expected_products.pop_front();
         if (row !== want.row) begin
            $error("out_row expected %0d got %0d", want.row, row);
            mismatches++;
         end
         if (col !== want.col) begin
            $error("out_col expected %0d got %0d", want.col, col);
            mismatches++;
         end
         if (value !== want.value) begin
            $error("product_value expected %0d got %0d", $signed(want.value), $signed(value));
            mismatches++;
         end
         if (last !== want.last) begin
            $error("last expected %0d got %0d", want.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;  // row, col, a_value, b_value
   logic                  req_tuser  = MODE_LOAD;  // mode
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;  // out_row, out_col, product_value
   logic                  rsp_tlast;  // last

   product_scoreboard sb = new();
   int                burst_left = 0;
   int unsigned       rsp_cycle  = 0;
   int                stall_style = 0;

   cannon_matrix_multiply uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // result side stalls, the style re-chosen at random among four styles
   always @(negedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 300 == 0) begin
         stall_style = $urandom_range(0, 3);
      end
      case (stall_style)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= (rsp_cycle % 4 == 0);
         end
         default: begin
            rsp_tready <= ((rsp_cycle / 7) % 3 != 0);
         end
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_result(rsp_tdata[IDX_W-1:0], rsp_tdata[2*IDX_W-1:IDX_W],
                         rsp_tdata[2*IDX_W+PROD_W-1:2*IDX_W], rsp_tlast);
      end
   end

   task automatic send_item(input logic mode, input logic [IDX_W-1:0] row,
                            input logic [IDX_W-1:0] col, input logic [ELEM_W-1:0] a_value,
                            input logic [ELEM_W-1:0] b_value);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_DATA_W'({b_value, a_value, col, row});
      do begin
         @(posedge clock);
      end while (!req_tready);
      sb.note_request(mode, row, col, a_value, b_value);
      burst_left--;
   endtask

   task automatic start_run();
      send_item(MODE_RUN, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom),
                ELEM_W'($urandom));
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      burst_left = 0;
   endtask

   function automatic logic [ELEM_W-1:0] pick_value();
      case ($urandom_range(0, 11))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // fill every element, largest positive a times most negative b
      for (int r = 0; r < DIM; r++) begin
         for (int c = 0; c < DIM; c++) begin
            send_item(MODE_LOAD, IDX_W'(r), IDX_W'(c), 16'h7fff, 16'h8000);
         end
      end
      start_run();
      // row 0 of a and column 0 of b at the most negative value
      for (int k = 0; k < DIM; k++) begin
         send_item(MODE_LOAD, 3'd0, IDX_W'(k), 16'h8000, (k == 0) ? 16'h8000 : 16'h8000);
      end
      for (int k = 1; k < DIM; k++) begin
         send_item(MODE_LOAD, IDX_W'(k), 3'd0, 16'h7fff, 16'h8000);
      end
      start_run();
      start_run();
      send_item(MODE_LOAD, 3'd7, 3'd7, 16'h0000, 16'h0000);
      send_item(MODE_LOAD, 3'd3, 3'd5, 16'h0001, 16'hffff);
      start_run();
      wait_for_drain();

      for (int n = 0; n < 280; n++) begin
         if ($urandom_range(1, RUN_ODDS) == 1) begin
            start_run();
         end else begin
            send_item(MODE_LOAD, IDX_W'($urandom), IDX_W'($urandom), pick_value(),
                      pick_value());
         end
         if (n == 140) begin
            wait_for_drain();
         end
      end
      start_run();

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("cannon_matrix_multiply: match");
      end else begin
         $display("cannon_matrix_multiply: mismatch");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("cannon_matrix_multiply: mismatch");
      $finish;
   end

endmodule
